// File: sv/tte_pkg.sv
// tte_pkg: shared types and constants of the text terminal escape engine
// parser phases, terminal state record, render command record, codes
// no dependencies
package tte_pkg;

    typedef enum logic [2:0] {
        PH_NORMAL   = 3'd0,
        PH_ACTIVE   = 3'd1,
        PH_PARAM    = 3'd2,
        PH_SPECIAL  = 3'd3,
        PH_TRANSFER = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  letter;
        logic [7:0]  first_arg;
        logic [15:0] skip;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [6:0]  attr;
        logic [3:0]  base_fg;
        logic [3:0]  base_bg;
        logic [3:0]  draw_fg;
        logic [3:0]  draw_bg;
        logic [3:0]  scr_colour;
        logic        cursor_en;
        logic        scroll_mode;
    } term_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [7:0]  glyph;
        logic [3:0]  ink_colour;
        logic [3:0]  paper_colour;
        logic [3:0]  fill_colour;
        logic [6:0]  attr_bits;
        logic [15:0] mouse_mask;
        logic        text_cursor_on;
        logic        last;
    } cmd_t;

    localparam logic [2:0] OP_GLYPH     = 3'd0;
    localparam logic [2:0] OP_ERASE_EOL = 3'd1;
    localparam logic [2:0] OP_ERASE_BLW = 3'd2;
    localparam logic [2:0] OP_INS_ROW   = 3'd3;
    localparam logic [2:0] OP_DEL_ROW   = 3'd4;
    localparam logic [2:0] OP_SCROLL    = 3'd5;
    localparam logic [2:0] OP_MOUSE     = 3'd6;

    localparam logic [7:0] CH_ENQ   = 8'h05;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HOME  = 8'h1C;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] POS_BIAS    = 8'h1F;
    localparam logic [7:0] COLOUR_SPLIT = 8'h3A;
    localparam logic [7:0] COLOUR_SHIFT = 8'h07;

    localparam logic [7:0] LT_T = 8'h54;
    localparam logic [7:0] LT_F = 8'h66;
    localparam logic [7:0] LT_Z = 8'h5A;
    localparam logic [7:0] LT_N = 8'h6E;
    localparam logic [7:0] LT_S = 8'h73;
    localparam logic [7:0] LT_R = 8'h72;
    localparam logic [7:0] LT_U = 8'h75;
    localparam logic [7:0] LT_LT = 8'h74;
    localparam logic [7:0] LT_J = 8'h4A;
    localparam logic [7:0] LT_K = 8'h4B;
    localparam logic [7:0] LT_L = 8'h4C;
    localparam logic [7:0] LT_M = 8'h4D;
    localparam logic [7:0] LT_V = 8'h76;
    localparam logic [7:0] LT_W = 8'h77;
    localparam logic [7:0] LT_A = 8'h61;
    localparam logic [7:0] LT_B = 8'h62;
    localparam logic [7:0] LT_C = 8'h63;
    localparam logic [7:0] LT_D = 8'h64;
    localparam logic [7:0] LT_E = 8'h65;
    localparam logic [7:0] LT_H = 8'h68;
    localparam logic [7:0] LT_X = 8'h78;
    localparam logic [7:0] LT_P = 8'h70;
    localparam logic [7:0] LT_Y = 8'h79;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [7:0] ROWS_RESET = 8'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    localparam int FIFO_DEPTH = 4;

    localparam term_state_t STATE_RESET = '{
        phase:       PH_NORMAL,
        letter:      8'd0,
        first_arg:   8'd0,
        skip:        16'd0,
        col:         8'd1,
        row:         8'd1,
        attr:        7'd0,
        base_fg:     4'd0,
        base_bg:     4'd8,
        draw_fg:     4'd0,
        draw_bg:     4'd8,
        scr_colour:  4'd8,
        cursor_en:   1'b1,
        scroll_mode: 1'b1
    };

endpackage

// File: sv/tte_cfg.sv
// tte_cfg: apb register file holding the screen geometry
// depends on tte_pkg
module tte_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  rows,
    output logic [7:0]  cols
);
    import tte_pkg::*;

    logic [7:0] rows_reg;
    logic [7:0] cols_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_ROWS) begin
                rows_reg <= pwdata[7:0];
            end else begin
                cols_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ROWS) begin
            prdata = {24'd0, rows_reg};
        end else begin
            prdata = {24'd0, cols_reg};
        end
    end

    assign rows = rows_reg;
    assign cols = cols_reg;

endmodule

// File: sv/tte_decode.sv
// tte_decode: escape parser and cursor logic for one byte
// gives the next terminal state and up to two render commands; depends on tte_pkg
module tte_decode #(
    parameter int TAB_STOP = 8
) (
    input  tte_pkg::term_state_t st,
    input  logic [7:0]           char_in,
    input  logic [7:0]           rows,
    input  logic [7:0]           cols,
    output tte_pkg::term_state_t st_next,
    output tte_pkg::cmd_t        cmd0,
    output tte_pkg::cmd_t        cmd1,
    output logic [1:0]           cmd_cnt
);
    import tte_pkg::*;

    logic [8:0] tab_tbl [256];
    logic [7:0] nrows;
    logic [7:0] ncols;
    logic [8:0] tab_col;
    logic [3:0] colour;
    logic       plain_go;
    logic       eol_ok;
    logic       row_on;
    phase_t     phase_next;

    // next tab stop for each column
    for (genvar i = 0; i < 256; i++) begin : g_tab
        localparam int NXT = ((i / TAB_STOP) + 1) * TAB_STOP;
        assign tab_tbl[i] = 9'(NXT);
    end

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [7:0] col,
                                      input logic [7:0] row, input logic [7:0] glyph,
                                      input logic [15:0] mask, input term_state_t s);
        cmd_t c;
        c.op             = op;
        c.cell_col       = col;
        c.cell_row       = row;
        c.glyph          = glyph;
        c.ink_colour     = s.draw_fg;
        c.paper_colour   = s.draw_bg;
        c.fill_colour    = s.scr_colour;
        c.attr_bits      = s.attr;
        c.mouse_mask     = mask;
        c.text_cursor_on = s.cursor_en;
        c.last           = 1'b0;
        return c;
    endfunction

    assign nrows   = (rows == 8'd0) ? 8'd1 : rows;
    assign ncols   = (cols == 8'd0) ? 8'd1 : cols;
    assign tab_col = tab_tbl[st.col];
    assign colour  = (char_in > COLOUR_SPLIT) ? 4'(char_in - COLOUR_SHIFT) : char_in[3:0];
    assign eol_ok  = (st.row != 8'd0) && (st.col != 8'd0) && (st.row <= nrows)
                     && (st.col <= ncols);
    assign row_on  = (st.row != 8'd0) && (st.row <= nrows);

    // parser phase
    always_comb begin
        phase_next = PH_NORMAL;
        plain_go   = 1'b0;
        case (st.phase)
            PH_ACTIVE: begin
                if (char_in == LT_T || char_in == LT_F || char_in == LT_Z ||
                    char_in == LT_N || char_in == LT_S || char_in == LT_R) begin
                    phase_next = PH_PARAM;
                end
            end
            PH_PARAM: begin
                if (st.letter == LT_T || st.letter == LT_F || st.letter == LT_Z) begin
                    phase_next = PH_SPECIAL;
                end
            end
            PH_SPECIAL: begin
                if (st.letter == LT_T) begin
                    phase_next = PH_TRANSFER;
                end
            end
            PH_TRANSFER: begin
                if (st.skip != 16'd0) begin
                    phase_next = PH_TRANSFER;
                end else begin
                    plain_go = 1'b1;
                end
            end
            default: begin
                if (char_in == CH_ESC) begin
                    phase_next = PH_ACTIVE;
                end else begin
                    plain_go = 1'b1;
                end
            end
        endcase
    end

    // state and commands
    always_comb begin
        st_next       = st;
        st_next.phase = phase_next;
        cmd0          = '0;
        cmd1          = '0;
        cmd_cnt       = 2'd0;

        case (st.phase)
            PH_ACTIVE: begin
                st_next.letter = char_in;
                case (char_in)
                    LT_U: st_next.scroll_mode = 1'b0;
                    LT_LT: st_next.scroll_mode = 1'b1;
                    LT_J: begin
                        if (eol_ok) begin
                            cmd0    = make_cmd(OP_ERASE_EOL, st.col, st.row, 8'd0, 16'd0, st);
                            cmd_cnt = 2'd1;
                        end
                        if (st.row < nrows) begin
                            if (eol_ok) begin
                                cmd1    = make_cmd(OP_ERASE_BLW, st.col, st.row, 8'd0,
                                                   16'd0, st);
                                cmd_cnt = 2'd2;
                            end else begin
                                cmd0    = make_cmd(OP_ERASE_BLW, st.col, st.row, 8'd0,
                                                   16'd0, st);
                                cmd_cnt = 2'd1;
                            end
                        end
                    end
                    LT_K: begin
                        if (eol_ok) begin
                            cmd0    = make_cmd(OP_ERASE_EOL, st.col, st.row, 8'd0, 16'd0, st);
                            cmd_cnt = 2'd1;
                        end
                    end
                    LT_L: begin
                        if (row_on) begin
                            cmd0    = make_cmd(OP_INS_ROW, st.col, st.row, 8'd0, 16'd0, st);
                            cmd_cnt = 2'd1;
                        end
                    end
                    LT_M: begin
                        if (row_on) begin
                            cmd0    = make_cmd(OP_DEL_ROW, st.col, st.row, 8'd0, 16'd0, st);
                            cmd_cnt = 2'd1;
                        end
                    end
                    LT_V: st_next.cursor_en = 1'b1;
                    LT_W: st_next.cursor_en = 1'b0;
                    LT_A: begin
                        st_next.attr    = 7'd0;
                        st_next.draw_fg = st.base_fg;
                        st_next.draw_bg = st.scr_colour;
                    end
                    LT_B: begin
                        st_next.attr    = 7'd0;
                        st_next.draw_fg = st.base_bg;
                        st_next.draw_bg = st.base_fg;
                    end
                    LT_C: st_next.attr = st.attr | 7'h01;
                    LT_D: st_next.attr = st.attr | 7'h02;
                    LT_E: st_next.attr = st.attr | 7'h04;
                    LT_H: st_next.attr = st.attr | 7'h08;
                    LT_X: st_next.attr = st.attr | 7'h10;
                    LT_P: st_next.attr = st.attr | 7'h20;
                    LT_Y: st_next.attr = st.attr | 7'h40;
                    default: ;
                endcase
            end
            PH_PARAM: begin
                if (st.letter == LT_T || st.letter == LT_F || st.letter == LT_Z) begin
                    st_next.first_arg = char_in;
                end else if (st.letter == LT_S) begin
                    st_next.base_bg = colour;
                    st_next.draw_bg = colour;
                end else if (st.letter == LT_N) begin
                    st_next.base_bg    = colour;
                    st_next.scr_colour = colour;
                end else if (st.letter == LT_R) begin
                    st_next.base_fg = colour;
                    st_next.draw_fg = colour;
                end
            end
            PH_SPECIAL: begin
                if (st.letter == LT_T) begin
                    st_next.skip = {char_in, st.first_arg};
                end else if (st.letter == LT_F) begin
                    st_next.col = (st.first_arg >= POS_BIAS) ? st.first_arg - POS_BIAS : 8'd0;
                    st_next.row = (char_in >= POS_BIAS) ? char_in - POS_BIAS : 8'd0;
                end else if (st.letter == LT_Z) begin
                    cmd0    = make_cmd(OP_MOUSE, st.col, st.row, 8'd0,
                                       {char_in, st.first_arg}, st);
                    cmd_cnt = 2'd1;
                end
            end
            PH_TRANSFER: begin
                if (st.skip != 16'd0) begin
                    st_next.skip = st.skip - 16'd1;
                end
            end
            default: ;
        endcase

        if (plain_go) begin
            case (char_in)
                CH_CR: st_next.col = 8'd1;
                CH_TAB: begin
                    if (tab_col > {1'b0, ncols}) begin
                        st_next.col = ncols;
                    end else begin
                        st_next.col = tab_col[7:0];
                    end
                end
                CH_FF: begin
                    st_next.col = 8'd1;
                    st_next.row = 8'd1;
                    cmd0        = make_cmd(OP_ERASE_EOL, 8'd1, 8'd1, 8'd0, 16'd0, st);
                    cmd_cnt     = 2'd1;
                    if (nrows > 8'd1) begin
                        cmd1    = make_cmd(OP_ERASE_BLW, 8'd1, 8'd1, 8'd0, 16'd0, st);
                        cmd_cnt = 2'd2;
                    end
                end
                CH_HOME: begin
                    st_next.col = 8'd1;
                    st_next.row = 8'd1;
                end
                CH_BS: begin
                    if (st.col > 8'd1) begin
                        st_next.col = st.col - 8'd1;
                    end else begin
                        st_next.col = ncols;
                        if (st.row > 8'd1) begin
                            st_next.row = st.row - 8'd1;
                        end
                    end
                end
                CH_VT: begin
                    if (st.row > 8'd1) begin
                        st_next.row = st.row - 8'd1;
                    end
                end
                CH_ENQ, CH_LF: begin
                    if (st.row < nrows) begin
                        st_next.row = st.row + 8'd1;
                    end else if (st.scroll_mode) begin
                        cmd0    = make_cmd(OP_SCROLL, st.col, st.row, 8'd0, 16'd0, st);
                        cmd_cnt = 2'd1;
                    end else begin
                        st_next.row = 8'd1;
                    end
                end
                default: begin
                    if (char_in >= CH_SPACE) begin
                        cmd0    = make_cmd(OP_GLYPH, st.col, st.row, char_in, 16'd0, st);
                        cmd_cnt = 2'd1;
                    end
                    if (char_in >= CH_SPACE || char_in == CH_ACK) begin
                        if (st.col < ncols) begin
                            st_next.col = st.col + 8'd1;
                        end else begin
                            st_next.col = 8'd1;
                            if (st.row < nrows) begin
                                st_next.row = st.row + 8'd1;
                            end else if (st.scroll_mode) begin
                                if (char_in >= CH_SPACE) begin
                                    cmd1    = make_cmd(OP_SCROLL, 8'd1, st.row, 8'd0,
                                                       16'd0, st);
                                    cmd_cnt = 2'd2;
                                end else begin
                                    cmd0    = make_cmd(OP_SCROLL, 8'd1, st.row, 8'd0,
                                                       16'd0, st);
                                    cmd_cnt = 2'd1;
                                end
                            end else begin
                                st_next.row = 8'd1;
                            end
                        end
                    end
                end
            endcase
        end

        if (cmd_cnt == 2'd1) begin
            cmd0.last = 1'b1;
        end else if (cmd_cnt == 2'd2) begin
            cmd1.last = 1'b1;
        end
    end

endmodule

// File: sv/tte_ofifo.sv
// tte_ofifo: small result queue taking up to two commands per cycle
// depends on tte_pkg
module tte_ofifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [1:0]     push_cnt,
    input  tte_pkg::cmd_t  push0,
    input  tte_pkg::cmd_t  push1,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output tte_pkg::cmd_t  out_cmd
);
    import tte_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr1;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr1   = wr_ptr_reg + PTR_W'(1);
    assign count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/text_terminal_escape_engine.sv
// text_terminal_escape_engine: escape-sequence console turning bytes into render commands
// depends on tte_pkg, tte_cfg, tte_decode, tte_ofifo
//
//  channel | ports                          | role
//  s_      | s_valid s_ready s_char_in      | one console byte per item
//  m_      | m_valid m_ready m_op ... m_last | one render command per item
//  apb     | psel penable pwrite paddr ...  | screen_rows at 0x0, screen_cols at 0x4
//
// a byte is registered, then decoded combinationally into zero to two commands
// that go into a four-entry result queue
// one byte per cycle while the queue has room for two commands; a byte giving
// two commands leaves as two m_ items, so the drain rate of m_ sets the pace
// aresetn is synchronous; stalls on m_ back up through the queue to s_ready
module text_terminal_escape_engine #(
    parameter int TAB_STOP = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_op,
    output logic [7:0]  m_cell_col,
    output logic [7:0]  m_cell_row,
    output logic [7:0]  m_glyph,
    output logic [3:0]  m_ink_colour,
    output logic [3:0]  m_paper_colour,
    output logic [3:0]  m_fill_colour,
    output logic [6:0]  m_attr_bits,
    output logic [15:0] m_mouse_mask,
    output logic        m_text_cursor_on,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tte_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_char_reg;
    term_state_t state_reg;
    term_state_t state_next;
    cmd_t        cmd0;
    cmd_t        cmd1;
    cmd_t        out_cmd;
    logic [1:0]  cmd_cnt;
    logic [1:0]  push_cnt;
    logic        room;
    logic        fire;
    logic [7:0]  rows;
    logic [7:0]  cols;

    tte_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows),
        .cols    (cols)
    );

    assign fire    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
        end
    end

    tte_decode #(
        .TAB_STOP (TAB_STOP)
    ) u_decode (
        .st      (state_reg),
        .char_in (in_char_reg),
        .rows    (rows),
        .cols    (cols),
        .st_next (state_next),
        .cmd0    (cmd0),
        .cmd1    (cmd1),
        .cmd_cnt (cmd_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign push_cnt = fire ? cmd_cnt : 2'd0;

    tte_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (cmd0),
        .push1     (cmd1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_cmd   (out_cmd)
    );

    assign m_op             = out_cmd.op;
    assign m_cell_col       = out_cmd.cell_col;
    assign m_cell_row       = out_cmd.cell_row;
    assign m_glyph          = out_cmd.glyph;
    assign m_ink_colour     = out_cmd.ink_colour;
    assign m_paper_colour   = out_cmd.paper_colour;
    assign m_fill_colour    = out_cmd.fill_colour;
    assign m_attr_bits      = out_cmd.attr_bits;
    assign m_mouse_mask     = out_cmd.mouse_mask;
    assign m_text_cursor_on = out_cmd.text_cursor_on;
    assign m_last           = out_cmd.last;

endmodule

// File: tb/tb_text_terminal_escape_engine.sv
// tb_text_terminal_escape_engine: self-checking bench for the escape-sequence console
// feeds console bytes, predicts every render command and checks them in order
// depends on tte_pkg and text_terminal_escape_engine
module tb_text_terminal_escape_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int TAB_STOP = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    localparam logic [6:0] ATTR_BLINK      = 7'h01;
    localparam logic [6:0] ATTR_UNDERLINE  = 7'h02;
    localparam logic [6:0] ATTR_LOW        = 7'h04;
    localparam logic [6:0] ATTR_HIGH       = 7'h08;
    localparam logic [6:0] ATTR_COMPRESSED = 7'h10;
    localparam logic [6:0] ATTR_PREFERRED  = 7'h20;
    localparam logic [6:0] ATTR_ITALIC     = 7'h40;

    localparam logic [7:0] OPENING [27] = '{
        8'h41, 8'hFF, CH_CR, CH_TAB, CH_BS, CH_VT, CH_ACK, CH_ENQ, 8'h00,
        CH_ESC, LT_L, CH_ESC, LT_M, CH_ESC, LT_J, CH_ESC, LT_Z, 8'h00, 8'hFF,
        CH_FF, CH_HOME, CH_ESC, LT_F, 8'h10, 8'h37, CH_LF, 8'h7E
    };

    localparam logic [7:0] CTRL_SET [10] = '{
        CH_CR, CH_TAB, CH_FF, CH_HOME, CH_BS, CH_VT, CH_ACK, CH_ENQ, CH_LF, CH_LF
    };

    localparam logic [7:0] PLAIN_LETTERS [17] = '{
        LT_U, LT_LT, LT_J, LT_K, LT_L, LT_M, LT_V, LT_W, LT_A, LT_B,
        LT_C, LT_D, LT_E, LT_H, LT_X, LT_P, LT_Y
    };

    localparam logic [7:0] COLOUR_LETTERS [3] = '{LT_N, LT_S, LT_R};

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_in = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_op;
    logic [7:0]  m_cell_col;
    logic [7:0]  m_cell_row;
    logic [7:0]  m_glyph;
    logic [3:0]  m_ink_colour;
    logic [3:0]  m_paper_colour;
    logic [3:0]  m_fill_colour;
    logic [6:0]  m_attr_bits;
    logic [15:0] m_mouse_mask;
    logic        m_text_cursor_on;
    logic        m_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    text_terminal_escape_engine #(
        .TAB_STOP(TAB_STOP)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_char_in(s_char_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_op(m_op),
        .m_cell_col(m_cell_col),
        .m_cell_row(m_cell_row),
        .m_glyph(m_glyph),
        .m_ink_colour(m_ink_colour),
        .m_paper_colour(m_paper_colour),
        .m_fill_colour(m_fill_colour),
        .m_attr_bits(m_attr_bits),
        .m_mouse_mask(m_mouse_mask),
        .m_text_cursor_on(m_text_cursor_on),
        .m_last(m_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // terminal state as the bench sees it
    logic [7:0]  cfg_rows = ROWS_RESET;
    logic [7:0]  cfg_cols = COLS_RESET;
    phase_t      prs_phase = STATE_RESET.phase;
    logic [7:0]  esc_letter = STATE_RESET.letter;
    logic [7:0]  esc_arg0 = STATE_RESET.first_arg;
    logic [15:0] skip_left = STATE_RESET.skip;
    logic [7:0]  cur_col = STATE_RESET.col;
    logic [7:0]  cur_row = STATE_RESET.row;
    logic [6:0]  attr_reg = STATE_RESET.attr;
    logic [3:0]  base_ink = STATE_RESET.base_fg;
    logic [3:0]  base_paper = STATE_RESET.base_bg;
    logic [3:0]  ink = STATE_RESET.draw_fg;
    logic [3:0]  paper = STATE_RESET.draw_bg;
    logic [3:0]  fill = STATE_RESET.scr_colour;
    logic        cursor_on = STATE_RESET.cursor_en;
    logic        scrolling = STATE_RESET.scroll_mode;

    cmd_t        step_cmds[$];
    cmd_t        cmd_expect_q[$];
    logic [7:0]  byte_q[$];

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold_req = 1'b0;
    logic        rx_block = 1'b0;
    int          errors = 0;
    int          queued_total = 0;
    int          geometries = 0;
    int          cmds_seen = 0;
    int          op_seen[7] = '{default: 0};

    function automatic int rows_eff();
        return (cfg_rows == 8'd0) ? 1 : int'(cfg_rows);
    endfunction

    function automatic int cols_eff();
        return (cfg_cols == 8'd0) ? 1 : int'(cfg_cols);
    endfunction

    function automatic void emit_cmd(input logic [2:0] op, input logic [7:0] ch,
                                     input logic [15:0] mask);
        cmd_t c;
        c.op = op;
        c.cell_col = cur_col;
        c.cell_row = cur_row;
        c.glyph = ch;
        c.ink_colour = ink;
        c.paper_colour = paper;
        c.fill_colour = fill;
        c.attr_bits = attr_reg;
        c.mouse_mask = mask;
        c.text_cursor_on = cursor_on;
        c.last = 1'b0;
        step_cmds.push_back(c);
    endfunction

    function automatic void erase_to_eol();
        if (cur_row != 0 && cur_col != 0 && cur_row <= rows_eff() && cur_col <= cols_eff())
            emit_cmd(OP_ERASE_EOL, 8'd0, 16'd0);
    endfunction

    function automatic void erase_down();
        erase_to_eol();
        if (cur_row < rows_eff())
            emit_cmd(OP_ERASE_BLW, 8'd0, 16'd0);
    endfunction

    function automatic void line_feed();
        if (cur_row < rows_eff()) begin
            cur_row = cur_row + 8'd1;
        end else if (scrolling) begin
            emit_cmd(OP_SCROLL, 8'd0, 16'd0);
        end else begin
            cur_row = 8'd1;
        end
    endfunction

    function automatic void step_right();
        if (cur_col < cols_eff()) begin
            cur_col = cur_col + 8'd1;
        end else begin
            cur_col = 8'd1;
            line_feed();
        end
    endfunction

    function automatic void print_char(input logic [7:0] c);
        int t;
        case (c)
            CH_CR: cur_col = 8'd1;
            CH_TAB: begin
                t = cur_col;
                do t++; while (t % TAB_STOP != 0);
                if (t > cols_eff())
                    t = cols_eff();
                cur_col = 8'(t);
            end
            CH_FF: begin
                cur_col = 8'd1;
                cur_row = 8'd1;
                erase_down();
                cur_col = 8'd1;
                cur_row = 8'd1;
            end
            CH_HOME: begin
                cur_col = 8'd1;
                cur_row = 8'd1;
            end
            CH_BS: begin
                if (cur_col > 1) begin
                    cur_col = cur_col - 8'd1;
                end else begin
                    cur_col = 8'(cols_eff());
                    if (cur_row > 1)
                        cur_row = cur_row - 8'd1;
                end
            end
            CH_VT: begin
                if (cur_row > 1)
                    cur_row = cur_row - 8'd1;
            end
            CH_ACK: step_right();
            CH_ENQ, CH_LF: line_feed();
            default: begin
                if (c >= CH_SPACE) begin
                    emit_cmd(OP_GLYPH, c, 16'd0);
                    step_right();
                end
            end
        endcase
    endfunction

    // advance the terminal by one byte and queue the commands it gives
    function automatic void terminal_step(input logic [7:0] c);
        logic [3:0] shade;
        cmd_t       tail;
        step_cmds.delete();
        case (prs_phase)
            PH_ACTIVE: begin
                esc_letter = c;
                prs_phase = PH_NORMAL;
                case (c)
                    LT_T, LT_F, LT_Z, LT_N, LT_S, LT_R: prs_phase = PH_PARAM;
                    LT_U: scrolling = 1'b0;
                    LT_LT: scrolling = 1'b1;
                    LT_J: erase_down();
                    LT_K: erase_to_eol();
                    LT_L: begin
                        if (cur_row >= 1 && cur_row <= rows_eff())
                            emit_cmd(OP_INS_ROW, 8'd0, 16'd0);
                    end
                    LT_M: begin
                        if (cur_row >= 1 && cur_row <= rows_eff())
                            emit_cmd(OP_DEL_ROW, 8'd0, 16'd0);
                    end
                    LT_V: cursor_on = 1'b1;
                    LT_W: cursor_on = 1'b0;
                    LT_A: begin
                        attr_reg = 7'd0;
                        ink = base_ink;
                        paper = fill;
                    end
                    LT_B: begin
                        attr_reg = 7'd0;
                        ink = base_paper;
                        paper = base_ink;
                    end
                    LT_C: attr_reg = attr_reg | ATTR_BLINK;
                    LT_D: attr_reg = attr_reg | ATTR_UNDERLINE;
                    LT_E: attr_reg = attr_reg | ATTR_LOW;
                    LT_H: attr_reg = attr_reg | ATTR_HIGH;
                    LT_X: attr_reg = attr_reg | ATTR_COMPRESSED;
                    LT_P: attr_reg = attr_reg | ATTR_PREFERRED;
                    LT_Y: attr_reg = attr_reg | ATTR_ITALIC;
                    default: ;
                endcase
            end
            PH_PARAM: begin
                prs_phase = PH_NORMAL;
                shade = (c > COLOUR_SPLIT) ? 4'(c - COLOUR_SHIFT) : c[3:0];
                if (esc_letter == LT_T || esc_letter == LT_F || esc_letter == LT_Z) begin
                    esc_arg0 = c;
                    prs_phase = PH_SPECIAL;
                end else if (esc_letter == LT_S) begin
                    base_paper = shade;
                    paper = shade;
                end else if (esc_letter == LT_N) begin
                    base_paper = shade;
                    fill = shade;
                end else if (esc_letter == LT_R) begin
                    base_ink = shade;
                    ink = shade;
                end
            end
            PH_SPECIAL: begin
                prs_phase = PH_NORMAL;
                if (esc_letter == LT_T) begin
                    skip_left = {c, esc_arg0};
                    prs_phase = PH_TRANSFER;
                end else if (esc_letter == LT_F) begin
                    cur_col = (esc_arg0 >= POS_BIAS) ? esc_arg0 - POS_BIAS : 8'd0;
                    cur_row = (c >= POS_BIAS) ? c - POS_BIAS : 8'd0;
                end else if (esc_letter == LT_Z) begin
                    emit_cmd(OP_MOUSE, 8'd0, {c, esc_arg0});
                end
            end
            PH_TRANSFER: begin
                if (skip_left != 0) begin
                    skip_left = skip_left - 16'd1;
                end else begin
                    prs_phase = PH_NORMAL;
                    print_char(c);
                end
            end
            default: begin
                prs_phase = PH_NORMAL;
                if (c == CH_ESC)
                    prs_phase = PH_ACTIVE;
                else
                    print_char(c);
            end
        endcase
        if (step_cmds.size() != 0) begin
            tail = step_cmds.pop_back();
            tail.last = 1'b1;
            step_cmds.push_back(tail);
        end
        foreach (step_cmds[i])
            cmd_expect_q.push_back(step_cmds[i]);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    function automatic void put(input logic [7:0] b);
        byte_q.push_back(b);
        queued_total++;
    endfunction

    // position byte for ESC f, mostly on the screen or just past its edge
    function automatic logic [7:0] aim(input int span);
        int pos;
        if ($urandom_range(4) == 0)
            pos = $urandom_range(255);
        else
            pos = POS_BIAS + $urandom_range(span + 1);
        return (pos > 255) ? 8'hFF : 8'(pos);
    endfunction

    // one well-formed sequence with random content, a noise byte, or ESC and a random byte
    function automatic void push_seq();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 30) begin
            n = $urandom_range(1, 6);
            repeat (n) put(8'($urandom_range(CH_SPACE, 255)));
        end else if (pick < 45) begin
            put(CTRL_SET[$urandom_range(9)]);
        end else if (pick < 55) begin
            b = 8'($urandom);
            put((b == CH_ESC) ? 8'h00 : b);
        end else if (pick < 75) begin
            put(CH_ESC);
            put(PLAIN_LETTERS[$urandom_range(16)]);
        end else if (pick < 82) begin
            put(CH_ESC);
            put(COLOUR_LETTERS[$urandom_range(2)]);
            put(8'($urandom));
        end else if (pick < 90) begin
            put(CH_ESC);
            put(LT_F);
            put(aim(cols_eff()));
            put(aim(rows_eff()));
        end else if (pick < 93) begin
            put(CH_ESC);
            put(LT_Z);
            put(8'($urandom));
            put(8'($urandom));
        end else if (pick < 97) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4);
            put(CH_ESC);
            put(LT_T);
            put(8'(n));
            put(8'd0);
            repeat (n) put(8'($urandom));
            put(($urandom_range(3) == 0) ? CH_ESC : 8'($urandom));
        end else begin
            b = 8'($urandom);
            if (b inside {LT_T, LT_F, LT_Z, LT_N, LT_S, LT_R})
                b = CH_ESC;
            put(CH_ESC);
            put(b);
        end
    endfunction

    function automatic void fill_bytes(input int n);
        int target;
        target = queued_total + n;
        while (queued_total < target)
            push_seq();
    endfunction

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_geometry(input logic [7:0] rows, input logic [7:0] cols);
        cfg_write({REG_ROWS, 2'b00}, {24'($urandom), rows});
        cfg_write({REG_COLS, 2'b00}, {24'($urandom), cols});
        cfg_rows = rows;
        cfg_cols = cols;
        geometries++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (byte_q.size() != 0 || s_valid || cmd_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                terminal_step(s_char_in);
            if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_char_in <= byte_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // command monitor
    always @(posedge aclk) begin
        cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            cmds_seen++;
            if (cmd_expect_q.size() == 0) begin
                errors++;
                $display("%0t: command op %0d with nothing expected", $time, m_op);
            end else begin
                want = cmd_expect_q.pop_front();
                check_field("op", want.op, m_op);
                check_field("cell_col", want.cell_col, m_cell_col);
                check_field("cell_row", want.cell_row, m_cell_row);
                check_field("glyph", want.glyph, m_glyph);
                check_field("ink_colour", want.ink_colour, m_ink_colour);
                check_field("paper_colour", want.paper_colour, m_paper_colour);
                check_field("fill_colour", want.fill_colour, m_fill_colour);
                check_field("attr_bits", want.attr_bits, m_attr_bits);
                check_field("mouse_mask", want.mouse_mask, m_mouse_mask);
                check_field("text_cursor_on", want.text_cursor_on, m_text_cursor_on);
                check_field("last", want.last, m_last);
            end
            if (m_op <= OP_MOUSE)
                op_seen[m_op]++;
        end
        m_ready <= !rx_block && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off so the result queue fills and s_ready drops
    initial begin
        wait (rx_hold_req);
        @(posedge aclk);
        rx_block <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_block <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAIL text_terminal_escape_engine");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 66;
        set_geometry(ROWS_RESET, COLS_RESET);
        foreach (OPENING[i])
            put(OPENING[i]);
        fill_bytes(280);
        wait_idle();

        set_geometry(8'd4, 8'd10);
        fill_bytes(280);
        rx_hold_req = 1'b1;
        wait_idle();

        tx_idle_pct = 66;
        rx_idle_pct = 12;
        set_geometry(8'd1, 8'd1);
        fill_bytes(280);
        wait_idle();

        set_geometry(8'd255, 8'd255);
        fill_bytes(280);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_geometry(8'd0, 8'd0);
        fill_bytes(140);
        wait_idle();
        fill_bytes(140);
        wait_idle();

        set_geometry(8'd3, 8'd16);
        // transparent skip with a nonzero high count byte
        put(CH_ESC);
        put(LT_T);
        put(8'd2);
        put(8'd1);
        repeat (258) put(8'($urandom));
        put(8'h41);
        fill_bytes(20);
        wait_idle();

        $display("run covered %0d bytes over %0d screen geometries, %0d commands checked",
                 queued_total, geometries, cmds_seen);
        $display("by op: glyph %0d eol %0d below %0d insert %0d delete %0d scroll %0d mouse %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
                 op_seen[6]);
        if (errors == 0 && cmd_expect_q.size() == 0) begin
            $display("PASS text_terminal_escape_engine");
        end else begin
            $display("FAIL text_terminal_escape_engine");
        end
        $finish;
    end

endmodule

// File: files.f
sv/tte_pkg.sv
sv/tte_cfg.sv
sv/tte_decode.sv
sv/tte_ofifo.sv
sv/text_terminal_escape_engine.sv
tb/tb_text_terminal_escape_engine.sv
